// ===== rtl/core/lapsa_pkg.sv =====
// Package for the load-aware PRB share allocator: word types, register indexes
// and divider handshake structs. Depends on nothing.
`timescale 1ns / 1ps
package lapsa_pkg;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;
  localparam int DIVD_W     = 25;
  localparam int DIVS_W     = 9;

  localparam logic [CFG_IDX_W-1:0] REG_RELAY_MASK   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_NODES = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ADAPTIVE_ON  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_SHARE   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL     = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_PRBS   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_QUOTA_FLOOR  = 4'd7;

  localparam logic [16:0] Q16_ONE  = 17'd65536;
  localparam logic [16:0] Q16_HALF = 17'd32768;

  typedef struct packed {
    logic [2:0]  node_slot;
    logic [3:0]  ue_slot;
    logic [15:0] ue_id;
    logic [63:0] byte_total;
    logic        report_end;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  out_node;
    logic [15:0] out_ue_id;
    logic [16:0] quota;
    logic        use_backhaul;
    logic        run_end;
  } out_word_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_word_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_UPD, S_END, S_SUM, S_TOT, S_FRAC, S_CMP, S_MUL,
    S_BGO, S_BWAIT, S_QGO, S_QWAIT, S_EMIT, S_ELD
  } state_e;

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

endpackage

// ===== rtl/core/lapsa_if.sv =====
// Channel interfaces for the allocator: entry input, quota output, config write.
// Depends on lapsa_pkg.
`timescale 1ns / 1ps
interface lapsa_in_if import lapsa_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lapsa_out_if import lapsa_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lapsa_cfg_if import lapsa_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/lapsa_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
module lapsa_ram #(
  parameter int W     = 64,
  parameter int DEPTH = 128,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);
  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule

// ===== rtl/core/lapsa_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on lapsa_pkg.
`timescale 1ns / 1ps
module lapsa_div import lapsa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);
  localparam int CW = $clog2(DIVD_W + 1);

  logic              busy_q, busy_d, done_q, done_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [DIVD_W-1:0] quo_q, quo_d;
  logic [DIVS_W-1:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [DIVS_W:0]   sh;
  logic              ge;

  always_comb begin
    sh     = {rem_q, quo_q[DIVD_W-1]};
    ge     = sh >= {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      // shift in one dividend bit, subtract when it fits
      rem_d = ge ? DIVS_W'(sh - {1'b0, dvs_q}) : sh[DIVS_W-1:0];
      quo_d = {quo_q[DIVD_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(DIVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;
endmodule

// ===== rtl/core/load_aware_prb_share_allocator_top.sv =====
// Top level of the load-aware PRB share allocator: control sequencer, counter
// and UE id memories, node loads and share arithmetic. Depends on lapsa_pkg,
// lapsa_if, lapsa_ram and lapsa_div.
`timescale 1ns / 1ps
// Usage: after reset the block sweeps all NODE_SLOTS*UES_PER_NODE counter
// entries (128 by default) to zero and takes no entry words meanwhile;
// configuration words are taken at any time. Items are handled one at a
// time. An entry with an in-range node and UE slot is read from the counter
// memory as it is taken; its new total and UE id are then written back in
// S_UPD. A report end adds the quota division on the shared serial divider
// and the emission of its quota words, as the UE id memory is read once per
// word; the output can stall this. When a share recomputation is due, the
// load sums, the bit-serial load fraction, the compare and PRB quantizing
// and, if the deviation exceeds the threshold, a divider pass for the new
// share come before the quota division.
module load_aware_prb_share_allocator_top import lapsa_pkg::*; #(
  parameter int NODE_SLOTS   = 8,
  parameter int UES_PER_NODE = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  lapsa_in_if.sink     in_i,
  lapsa_out_if.source  out_o,
  lapsa_cfg_if.sink    cfg_i
);
  localparam int DEPTH = NODE_SLOTS * UES_PER_NODE;
  localparam int AW    = $clog2(DEPTH);
  localparam int NIW   = $clog2(NODE_SLOTS);
  localparam int NCW   = $clog2(NODE_SLOTS + 1);
  localparam int NMAX  = (UES_PER_NODE < 16) ? UES_PER_NODE : 16;

  // configuration registers
  logic [7:0]  relay_q;
  logic [3:0]  active_q;
  logic        adapt_q;
  logic [7:0]  interval_q;
  logic [15:0] thresh_q;
  logic [8:0]  prbs_q;
  logic [16:0] floor_q;
  logic [16:0] bh_share_q;

  state_e state_q, state_d;

  // latched entry word
  logic [2:0]  node_q;
  logic [3:0]  slot_q;
  logic [15:0] id_q;
  logic [63:0] cur_q;
  logic        end_q;

  logic [63:0] sum_q;
  logic [7:0]  rcount_q;
  logic [63:0] load_q [NODE_SLOTS];
  logic [63:0] bh_q, ac_q, tot_q, r_q;
  logic [NCW-1:0] rc_q;
  logic [16:0] rho_q, k_q, quota_q;
  logic [3:0]  it_q;
  logic [4:0]  n_q, i_q;
  logic [AW-1:0] clr_q;
  logic        recomp_q;

  logic        out_valid_q;
  out_word_t   out_q;

  // control strobes
  logic        in_take, lc_re, lc_we, id_we, id_re, out_load, cfg_take;
  logic [AW-1:0] lc_raddr, lc_waddr, id_raddr, ent_addr;
  logic [63:0] lc_wdata, lc_rdata;
  logic [15:0] id_rdata;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  // derived values
  logic          in_node_ok, in_slot_ok, slot_ok;
  logic [63:0]   delta;
  logic [NCW-1:0] n_act;
  logic [3:0]    rc_node;
  logic          rc_relay;
  logic [64:0]   twice_r;
  logic          frac_ge;
  logic [16:0]   rho_dev;
  logic [8:0]    p_eff;
  logic [25:0]   rho_p;
  logic [7:0]    cnt_next, int_eff;
  logic [16:0]   share;
  logic [16:0]   q_raw;
  logic [4:0]    n_calc;

  assign in_node_ok = int'(in_i.data.node_slot) < NODE_SLOTS;
  assign in_slot_ok = int'(in_i.data.ue_slot) < UES_PER_NODE;
  assign slot_ok    = int'(slot_q) < UES_PER_NODE;
  assign ent_addr   = AW'(int'(node_q) * UES_PER_NODE + int'(slot_q));
  assign delta      = (cur_q >= lc_rdata) ? cur_q - lc_rdata : 64'd0;
  assign n_act      = (int'(active_q) < NODE_SLOTS) ? NCW'(active_q) : NCW'(NODE_SLOTS);
  assign rc_node    = 4'(rc_q);
  assign rc_relay   = (rc_node < 4'd8) && relay_q[rc_node[2:0]];
  assign twice_r    = {r_q, 1'b0};
  assign frac_ge    = twice_r >= {1'b0, tot_q};
  assign rho_dev    = (rho_q > Q16_HALF) ? rho_q - Q16_HALF : Q16_HALF - rho_q;
  assign p_eff      = (prbs_q == 9'd0) ? 9'd1 : prbs_q;
  assign rho_p      = 26'(rho_q) * 26'(p_eff);
  assign int_eff    = (interval_q == 8'd0) ? 8'd1 : interval_q;
  assign cnt_next   = rcount_q + 8'd1;
  assign share      = relay_q[node_q] ? bh_share_q : Q16_ONE - bh_share_q;
  assign q_raw      = div_rsp.quotient[16:0];
  assign n_calc     = (({1'b0, slot_q} + 5'd1) > 5'(NMAX)) ? 5'(NMAX)
                                                            : {1'b0, slot_q} + 5'd1;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLR:   if (clr_q == AW'(DEPTH - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (in_i.valid && in_node_ok) begin
          if (in_slot_ok) state_d = S_UPD;
          else if (in_i.data.report_end) state_d = S_END;
        end
      end
      S_UPD:   state_d = end_q ? S_END : S_IDLE;
      S_END: begin
        if (adapt_q && (cnt_next >= int_eff)) state_d = S_SUM;
        else state_d = S_QGO;
      end
      S_SUM:   if (rc_q == n_act) state_d = S_TOT;
      S_TOT:   state_d = S_FRAC;
      S_FRAC:  if (recomp_q || it_q == 4'd15) state_d = S_CMP;
      S_CMP:   state_d = ({1'b0, rho_dev} > {2'b0, thresh_q}) ? S_MUL : S_QGO;
      S_MUL:   state_d = S_BGO;
      S_BGO:   state_d = S_BWAIT;
      S_BWAIT: if (div_rsp.done) state_d = S_QGO;
      S_QGO:   state_d = S_QWAIT;
      S_QWAIT: if (div_rsp.done) state_d = S_EMIT;
      S_EMIT:  if (!out_valid_q || out_o.ready) state_d = S_ELD;
      S_ELD:   state_d = ((i_q + 5'd1) == n_q) ? S_IDLE : S_EMIT;
      default: state_d = S_IDLE;
    endcase
  end

  // strobes
  always_comb begin
    in_take          = (state_q == S_IDLE) && in_i.valid;
    lc_re            = in_take;
    lc_raddr         = AW'(int'(in_i.data.node_slot) * UES_PER_NODE
                           + int'(in_i.data.ue_slot));
    lc_we            = (state_q == S_CLR) || ((state_q == S_UPD) && slot_ok);
    lc_waddr         = (state_q == S_CLR) ? clr_q : ent_addr;
    lc_wdata         = (state_q == S_CLR) ? 64'd0 : cur_q;
    id_we            = (state_q == S_UPD) && slot_ok;
    id_re            = (state_q == S_EMIT) && (!out_valid_q || out_o.ready);
    id_raddr         = AW'(int'(node_q) * UES_PER_NODE + int'(i_q));
    out_load         = (state_q == S_ELD);
    div_req.start    = (state_q == S_BGO) || (state_q == S_QGO);
    div_req.dividend = (state_q == S_BGO) ? {k_q[8:0], 16'd0} : DIVD_W'(share);
    // n_q is only loaded at this step, so divide by the UE count directly
    div_req.divisor  = (state_q == S_BGO) ? p_eff : DIVS_W'(n_calc);
    cfg_take         = cfg_i.valid;
  end

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  lapsa_ram #(.W(64), .DEPTH(DEPTH)) u_counter_ram (
    .clk_i, .we_i(lc_we), .waddr_i(lc_waddr), .wdata_i(lc_wdata),
    .re_i(lc_re), .raddr_i(lc_raddr), .rdata_o(lc_rdata)
  );

  lapsa_ram #(.W(16), .DEPTH(DEPTH)) u_ueid_ram (
    .clk_i, .we_i(id_we), .waddr_i(ent_addr), .wdata_i(id_q),
    .re_i(id_re), .raddr_i(id_raddr), .rdata_o(id_rdata)
  );

  lapsa_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      relay_q     <= 8'd0;
      active_q    <= 4'd5;
      adapt_q     <= 1'b0;
      interval_q  <= 8'd10;
      thresh_q    <= 16'd6554;
      prbs_q      <= 9'd106;
      floor_q     <= 17'd655;
      bh_share_q  <= 17'd32768;
      sum_q       <= '0;
      rcount_q    <= '0;
      out_valid_q <= 1'b0;
      for (int j = 0; j < NODE_SLOTS; j++) begin
        load_q[j] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == S_CLR) clr_q <= clr_q + 1'b1;
      if (cfg_take) begin
        case (cfg_i.data.index)
          REG_RELAY_MASK:   relay_q    <= cfg_i.data.value[7:0];
          REG_ACTIVE_NODES: active_q   <= cfg_i.data.value[3:0];
          REG_ADAPTIVE_ON:  adapt_q    <= cfg_i.data.value[0];
          REG_INIT_SHARE: begin
            // clamp to the full carrier
            bh_share_q <= (cfg_i.data.value[16:0] > Q16_ONE) ? Q16_ONE
                                                             : cfg_i.data.value[16:0];
          end
          REG_INTERVAL:     interval_q <= cfg_i.data.value[7:0];
          REG_THRESHOLD:    thresh_q   <= cfg_i.data.value[15:0];
          REG_TOTAL_PRBS:   prbs_q     <= cfg_i.data.value[8:0];
          REG_QUOTA_FLOOR:  floor_q    <= cfg_i.data.value[16:0];
          default: ;
        endcase
      end
      // accumulate the report sum from the counter delta
      if (state_q == S_UPD && slot_ok) sum_q <= sat_add64(sum_q, delta);
      if (state_q == S_END) begin
        load_q[NIW'(node_q)] <= sum_q;
        sum_q <= '0;
        if (adapt_q) rcount_q <= (cnt_next >= int_eff) ? 8'd0 : cnt_next;
      end
      if (state_q == S_BWAIT && div_rsp.done) bh_share_q <= q_raw;
      // drop the output word on handshake, load a new one from the sequencer
      if (out_load) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      node_q <= in_i.data.node_slot;
      slot_q <= in_i.data.ue_slot;
      id_q   <= in_i.data.ue_id;
      cur_q  <= in_i.data.byte_total;
      end_q  <= in_i.data.report_end;
    end
    case (state_q)
      S_END: begin
        bh_q <= '0;
        ac_q <= '0;
        rc_q <= '0;
      end
      S_SUM: begin
        if (rc_q != n_act) begin
          if (rc_relay) bh_q <= sat_add64(bh_q, load_q[NIW'(rc_q)]);
          else ac_q <= sat_add64(ac_q, load_q[NIW'(rc_q)]);
          rc_q <= rc_q + 1'b1;
        end
      end
      S_TOT: begin
        tot_q <= sat_add64(sat_add64(bh_q, ac_q), 64'd1);
        r_q   <= bh_q;
        it_q  <= '0;
        rho_q <= '0;
      end
      S_FRAC: begin
        // one quotient bit of the load fraction per cycle
        if (bh_q >= tot_q) begin
          recomp_q <= 1'b1;
          rho_q    <= Q16_ONE;
        end else begin
          recomp_q <= 1'b0;
          r_q      <= frac_ge ? 64'(twice_r - {1'b0, tot_q}) : twice_r[63:0];
          rho_q    <= {rho_q[15:0], frac_ge};
          it_q     <= it_q + 4'd1;
        end
      end
      S_MUL:   k_q <= {8'd0, rho_p[24:16]};
      S_QGO:   n_q <= n_calc;
      S_QWAIT: begin
        if (div_rsp.done) begin
          if (q_raw < floor_q) quota_q <= (floor_q > Q16_ONE) ? Q16_ONE : floor_q;
          else quota_q <= (q_raw > Q16_ONE) ? Q16_ONE : q_raw;
          i_q <= '0;
        end
      end
      S_ELD: i_q <= i_q + 5'd1;
      default: begin
        recomp_q <= 1'b0;
      end
    endcase
    if (out_load) begin
      out_q.out_node     <= node_q;
      out_q.out_ue_id    <= id_rdata;
      out_q.quota        <= quota_q;
      out_q.use_backhaul <= relay_q[node_q];
      out_q.run_end      <= (i_q + 5'd1) == n_q;
    end
  end

`ifndef SYNTHESIS
  // an output word is only loaded into an empty output register
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_load |-> !out_valid_q)
    else $error("output register overwritten");
  // no entry is taken while the divider is running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (in_i.valid && in_i.ready) |-> !div_rsp.busy)
    else $error("entry accepted during division");
  // the backhaul share never exceeds the full carrier
  assert property (@(posedge clk_i) disable iff (!rst_ni) bh_share_q <= Q16_ONE)
    else $error("backhaul share out of range");
  // a quota division result is followed by the emit step of the sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (div_rsp.done && state_q == S_QWAIT) |=> state_q == S_EMIT)
    else $error("quota division result lost");
`endif
endmodule

// ===== tb/tb_lapsa_quota_checker.sv =====
// Quota checker for the load-aware PRB share allocator: watches the entry,
// quota and config channels, predicts every quota word and compares it.
// Depends on lapsa_pkg and lapsa_if.
`timescale 1ns / 1ps
module tb_lapsa_quota_checker import lapsa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  lapsa_in_if  in_i,
  lapsa_out_if out_i,
  lapsa_cfg_if cfg_i,
  output int   fail_cnt_o,
  output int   pending_o,
  output int   quota_cnt_o,
  output int   recompute_cnt_o
);

  localparam int NODES = 8;
  localparam int UES   = 16;

  logic [63:0] prev_bytes [NODES*UES];
  logic [15:0] slot_ids   [NODES*UES];
  logic [63:0] node_bytes [NODES];
  logic [63:0] run_bytes;
  logic [16:0] bh_share;
  logic [7:0]  rep_cnt;

  logic [7:0]  relay_mask;
  logic [3:0]  active_nodes;
  logic        adaptive_on;
  logic [7:0]  interval;
  logic [15:0] threshold;
  logic [8:0]  prbs;
  logic [16:0] floor_q16;

  out_word_t quota_q [$];

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

  // Bit-serial floor(65536*num/den), written so no step can overflow.
  function automatic logic [16:0] load_fraction(logic [63:0] num, logic [63:0] den);
    logic [63:0] r;
    logic [16:0] q;
    r = num;
    q = '0;
    if (num >= den) return Q16_ONE;
    for (int i = 0; i < 16; i++) begin
      if (r >= den - r) begin
        q = {q[15:0], 1'b1};
        r = r - (den - r);
      end else begin
        q = {q[15:0], 1'b0};
        r = r + r;
      end
    end
    return q;
  endfunction

  task automatic recompute_share();
    logic [63:0] bh, ac, tot;
    logic [16:0] rho, rho_dev;
    logic [31:0] p, k;
    logic [47:0] scaled;
    int n;
    bh = '0;
    ac = '0;
    n = (active_nodes < NODES) ? active_nodes : NODES;
    for (int i = 0; i < n; i++) begin
      if (relay_mask[i]) bh = sat_sum(bh, node_bytes[i]);
      else ac = sat_sum(ac, node_bytes[i]);
    end
    tot = sat_sum(sat_sum(bh, ac), 64'd1);
    rho = load_fraction(bh, tot);
    rho_dev = (rho > Q16_HALF) ? rho - Q16_HALF : Q16_HALF - rho;
    recompute_cnt_o++;
    if (rho_dev > {1'b0, threshold}) begin
      p = (prbs == 0) ? 32'd1 : {23'd0, prbs};
      scaled = {31'd0, rho} * p;
      k = scaled[47:16];
      bh_share = 17'(({16'd0, k} << 16) / p);
    end
  endtask

  task automatic predict_entry(in_word_t w);
    int ix, n;
    logic [63:0] d;
    logic [16:0] share, quota;
    logic relay;
    out_word_t o;
    ix = w.node_slot * UES + w.ue_slot;
    d = (w.byte_total >= prev_bytes[ix]) ? w.byte_total - prev_bytes[ix] : 64'd0;
    prev_bytes[ix] = w.byte_total;
    slot_ids[ix] = w.ue_id;
    run_bytes = sat_sum(run_bytes, d);
    if (!w.report_end) return;
    node_bytes[w.node_slot] = run_bytes;
    run_bytes = '0;
    if (adaptive_on) begin
      rep_cnt = rep_cnt + 8'd1;
      if (rep_cnt >= ((interval == 0) ? 8'd1 : interval)) begin
        rep_cnt = '0;
        recompute_share();
      end
    end
    n = w.ue_slot + 1;
    relay = relay_mask[w.node_slot];
    share = relay ? bh_share : Q16_ONE - bh_share;
    quota = share / n;
    if (quota < floor_q16) quota = floor_q16;
    if (quota > Q16_ONE) quota = Q16_ONE;
    for (int i = 0; i < n; i++) begin
      o.out_node     = w.node_slot;
      o.out_ue_id    = slot_ids[w.node_slot * UES + i];
      o.quota        = quota;
      o.use_backhaul = relay;
      o.run_end      = (i + 1 == n);
      quota_q.push_back(o);
    end
  endtask

  task automatic apply_cfg(cfg_word_t c);
    case (c.index)
      REG_RELAY_MASK:   relay_mask = c.value[7:0];
      REG_ACTIVE_NODES: active_nodes = c.value[3:0];
      REG_ADAPTIVE_ON:  adaptive_on = c.value[0];
      REG_INIT_SHARE:   bh_share = (c.value[16:0] > Q16_ONE) ? Q16_ONE : c.value[16:0];
      REG_INTERVAL:     interval = c.value[7:0];
      REG_THRESHOLD:    threshold = c.value[15:0];
      REG_TOTAL_PRBS:   prbs = c.value[8:0];
      REG_QUOTA_FLOOR:  floor_q16 = c.value[16:0];
      default: ;
    endcase
  endtask

  task automatic check_quota(out_word_t act);
    out_word_t e;
    if (quota_q.size() == 0) begin
      fail_cnt_o++;
      $display("%0t: unexpected quota word %p", $time, act);
      return;
    end
    e = quota_q.pop_front();
    quota_cnt_o++;
    if (act.out_node !== e.out_node || act.out_ue_id !== e.out_ue_id ||
        act.quota !== e.quota || act.use_backhaul !== e.use_backhaul ||
        act.run_end !== e.run_end) begin
      fail_cnt_o++;
      $display("%0t: quota mismatch expected %p actual %p", $time, e, act);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (prev_bytes[i]) prev_bytes[i] = '0;
      foreach (slot_ids[i]) slot_ids[i] = '0;
      foreach (node_bytes[i]) node_bytes[i] = '0;
      run_bytes = '0;
      rep_cnt = '0;
      relay_mask = 8'd0;
      active_nodes = 4'd5;
      adaptive_on = 1'b0;
      bh_share = 17'd32768;
      interval = 8'd10;
      threshold = 16'd6554;
      prbs = 9'd106;
      floor_q16 = 17'd655;
      quota_q.delete();
      fail_cnt_o = 0;
      quota_cnt_o = 0;
      recompute_cnt_o = 0;
    end else begin
      // Sample everything before the edge updates land: outputs first.
      if (out_i.valid && out_i.ready) check_quota(out_i.data);
      if (cfg_i.valid && cfg_i.ready) apply_cfg(cfg_i.data);
      if (in_i.valid && in_i.ready) predict_entry(in_i.data);
    end
    pending_o = quota_q.size();
  end

endmodule

// ===== tb/tb_load_aware_prb_share_allocator_top.sv =====
// Testbench top for the load-aware PRB share allocator: clock, reset, entry and
// config stimulus, quota back-pressure and verdict. Depends on lapsa_pkg,
// lapsa_if, the allocator top and tb_lapsa_quota_checker.
`timescale 1ns / 1ps
module tb_load_aware_prb_share_allocator_top;
  import lapsa_pkg::*;

  localparam int RAND_PER_PHASE = 40;
  localparam int SETTLE_CYCLES  = 150;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lapsa_in_if  in_if ();
  lapsa_out_if out_if ();
  lapsa_cfg_if cfg_if ();

  int fail_cnt, pending, quota_cnt, recompute_cnt;
  int entry_cnt;
  bit no_idle;                      // stretch without gaps on either side
  bit written [8][16];              // UE slots whose id has been set
  logic [63:0] last_bytes [8][16];  // sender's copy, to build growing counters

  load_aware_prb_share_allocator_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  tb_lapsa_quota_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_i            (in_if),
    .out_i           (out_if),
    .cfg_i           (cfg_if),
    .fail_cnt_o      (fail_cnt),
    .pending_o       (pending),
    .quota_cnt_o     (quota_cnt),
    .recompute_cnt_o (recompute_cnt)
  );

  always #5 clk_i = ~clk_i;

  // Hard stop in case the block hangs.
  initial begin
    #20ms;
    $display("tb_load_aware_prb_share_allocator_top: FAIL");
    $finish;
  end

  // Mostly short gaps, a few long ones, none during a burst stretch.
  function automatic int gap_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Stall the quota channel at random; drive at the falling edge.
  initial begin
    int hold;
    out_if.ready = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        out_if.ready = 1'b0;
        hold--;
      end else begin
        out_if.ready = 1'b1;
        hold = gap_len();
      end
    end
  end

  // Present one entry word at a falling edge and hold it until taken.
  task automatic send_entry(in_word_t w);
    int g;
    in_if.valid = 1'b1;
    in_if.data = w;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    written[w.node_slot][w.ue_slot] = 1'b1;
    last_bytes[w.node_slot][w.ue_slot] = w.byte_total;
    entry_cnt++;
    @(negedge clk_i);
    g = gap_len();
    if (g > 0) begin
      in_if.valid = 1'b0;
      repeat (g) @(negedge clk_i);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_if.valid = 1'b1;
    cfg_if.data.index = idx;
    cfg_if.data.value = val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // Drain every expected quota, then let trailing work settle.
  task automatic wait_drained();
    in_if.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic load_cfg(logic [7:0] relay, logic [3:0] act, logic adapt,
                          logic [16:0] init, logic [7:0] intv, logic [15:0] thr,
                          logic [8:0] prb, logic [16:0] flr);
    wait_drained();
    write_reg(REG_RELAY_MASK, 32'(relay));
    write_reg(REG_ACTIVE_NODES, 32'(act));
    write_reg(REG_ADAPTIVE_ON, 32'(adapt));
    write_reg(REG_INIT_SHARE, 32'(init));
    write_reg(REG_INTERVAL, 32'(intv));
    write_reg(REG_THRESHOLD, 32'(thr));
    write_reg(REG_TOTAL_PRBS, 32'(prb));
    write_reg(REG_QUOTA_FLOOR, 32'(flr));
  endtask

  function automatic in_word_t mk(int node, int slot, logic [15:0] id,
                                  logic [63:0] bytes, bit last);
    in_word_t w;
    w.node_slot = node[2:0];
    w.ue_slot = slot[3:0];
    w.ue_id = id;
    w.byte_total = bytes;
    w.report_end = last;
    return w;
  endfunction

  function automatic logic [63:0] next_bytes(int node, int slot);
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return last_bytes[node][slot] + $urandom_range(0, 200000);
    if (r < 85) return last_bytes[node][slot] - $urandom_range(0, 1000);
    return {$urandom, $urandom};
  endfunction

  // A well-formed report: UE slots 0..last in order, end on the last.
  task automatic send_report();
    int node, last;
    node = $urandom_range(0, 7);
    last = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 4);
    for (int s = 0; s <= last; s++)
      send_entry(mk(node, s, 16'($urandom), next_bytes(node, s), s == last));
  endtask

  // A stray entry; may end a report only if its node's lower slot ids are set.
  task automatic send_noise();
    int node, slot;
    bit last, ok;
    node = $urandom_range(0, 7);
    slot = $urandom_range(0, 15);
    ok = 1'b1;
    for (int s = 0; s < slot; s++) if (!written[node][s]) ok = 1'b0;
    last = ok && ($urandom_range(0, 2) == 0);
    send_entry(mk(node, slot, 16'($urandom), {$urandom, $urandom}, last));
  endtask

  task automatic random_phase();
    int sent;
    sent = entry_cnt;
    while (entry_cnt - sent < RAND_PER_PHASE) begin
      if ($urandom_range(0, 15) == 0) no_idle = ~no_idle;
      // Hold off now and then until every quota is out.
      if ($urandom_range(0, 19) == 0) begin
        in_if.valid = 1'b0;
        while (pending != 0) @(negedge clk_i);
      end
      if ($urandom_range(0, 3) == 0) send_noise();
      else send_report();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    entry_cnt = 0;
    no_idle = 1'b0;
    foreach (written[n, s]) begin
      written[n][s] = 1'b0;
      last_bytes[n][s] = '0;
    end
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: full 16-UE report with counter extremes, top node and id
    // extremes, counter going backwards, a mixed report, saturating sums.
    for (int s = 0; s < 16; s++)
      send_entry(mk(0, s, 16'(s * 4099), (s == 0) ? '1 : '0, s == 15));
    send_entry(mk(7, 0, 16'hFFFF, 64'd0, 1'b1));
    send_entry(mk(0, 0, 16'h0000, 64'd5, 1'b1));
    send_entry(mk(3, 0, 16'h0000, 64'd100, 1'b0));
    send_entry(mk(0, 1, 16'h8001, 64'd7, 1'b1));
    send_entry(mk(0, 0, 16'h1234, '1, 1'b0));
    send_entry(mk(0, 1, 16'h4321, '1, 1'b1));

    random_phase();
    load_cfg(8'hA5, 4'd5, 1'b1, 17'd32768, 8'd1, 16'd0, 9'd106, 17'd655);
    random_phase();
    // Active nodes past the slot count, zero interval and PRBs, top threshold.
    load_cfg(8'hFF, 4'd15, 1'b1, 17'd0, 8'd0, 16'd32768, 9'd0, 17'd0);
    random_phase();
    load_cfg(8'h00, 4'd1, 1'b1, 17'd65536, 8'd255, 16'd1000, 9'd275, 17'd65536);
    random_phase();
    // Share and floor registers above one.
    load_cfg(8'h0F, 4'd8, 1'b1, 17'h1FFFF, 8'd3, 16'd6554, 9'd1, 17'd70000);
    random_phase();
    load_cfg(8'h81, 4'd0, 1'b0, 17'd12345, 8'd2, 16'd100, 9'd50, 17'd1);
    random_phase();
    load_cfg(8'h5A, 4'd4, 1'b1, 17'd20000, 8'd1, 16'd3000, 9'd106, 17'd655);
    random_phase();

    wait_drained();
    $display("Covered %0d entry words under 7 register settings.", entry_cnt);
    $display("Checked %0d quota words across %0d share recomputations.",
             quota_cnt, recompute_cnt);
    if (fail_cnt == 0) begin
      $display("tb_load_aware_prb_share_allocator_top: PASS");
    end else begin
      $display("tb_load_aware_prb_share_allocator_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/lapsa_pkg.sv
rtl/core/lapsa_if.sv
rtl/core/lapsa_ram.sv
rtl/core/lapsa_div.sv
rtl/core/load_aware_prb_share_allocator_top.sv
tb/tb_lapsa_quota_checker.sv
tb/tb_load_aware_prb_share_allocator_top.sv
